@@ hdl/imk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package imk_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 10;
  localparam int DIVIDEND_W = 13;   // holds 6000
  localparam int DIVISOR_W  = 8;    // sample/7 + 50 tops out at 196
  localparam int DOT_W      = 7;    // dot length 30..120
  localparam int TICK_W     = 9;
  localparam int PROD_W     = 22;   // 10-bit sample times 12-bit reciprocal
  localparam int RECIP_W    = 12;
  localparam int RECIP_SH   = 14;

  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = 4;

  // 6000 / (sample / 7 + 50)
  localparam logic [DIVIDEND_W-1:0] DOT_NUM    = 13'd6000;
  // floor(x * 2341 / 2^14) == floor(x / 7) for every 10-bit x
  localparam logic [RECIP_W-1:0]    RECIP7     = 12'd2341;
  localparam logic [DIVISOR_W-1:0]  DIV_OFFSET = 8'd50;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DASH     = 3'd1,
    PH_DOT      = 3'd2,
    PH_GAP_DASH = 3'd3,
    PH_GAP_DOT  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_DASH = 2'd1,
    PEND_DOT  = 2'd2
  } pend_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SCALE,
    SQ_START,
    SQ_DIV,
    SQ_PUSH
  } seq_t;

  // Request from the sequencer to the keyer state update
  typedef struct packed {
    logic             upd;
    logic             dash;
    logic             dot;
    logic [DOT_W-1:0] dot_len;
  } step_req_t;

endpackage

`default_nettype wire

@@ hdl/imk_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module imk_div
  import imk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DOT_W-1:0]           quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  // quotient never exceeds 120
  assign quotient = quo_r[DOT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/imk_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Keyer element/gap state, advanced once per tick.
module imk_step
  import imk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire step_req_t req,
  output logic           key
);

  phase_t              phase_r, phase_nxt;
  pend_t               pend_r, pend_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;

  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   dot_lim;
  logic [TICK_W-1:0]   dash_lim;
  logic                dot_end;
  logic                dash_end;
  pend_t               pend_mid;

  assign tick_inc = tick_r + 1'b1;
  assign dot_lim  = TICK_W'(req.dot_len);
  assign dash_lim = dot_lim + {dot_lim[TICK_W-2:0], 1'b0};
  assign dot_end  = (tick_inc >= dot_lim);
  assign dash_end = (tick_inc >= dash_lim);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    tick_nxt  = tick_r;
    pend_mid  = pend_r;
    if (req.upd) begin
      unique case (phase_r)
        PH_DASH: begin
          tick_nxt = tick_inc;
          if (req.dot) pend_nxt = PEND_DOT;
          if (dash_end) begin
            phase_nxt = PH_GAP_DASH;
            tick_nxt  = '0;
          end
        end
        PH_DOT: begin
          tick_nxt = tick_inc;
          if (req.dash) pend_nxt = PEND_DASH;
          if (dot_end) begin
            phase_nxt = PH_GAP_DOT;
            tick_nxt  = '0;
          end
        end
        PH_GAP_DASH, PH_GAP_DOT: begin
          tick_nxt = tick_inc;
          // opposite paddle always wins; same paddle only into an empty slot
          if (phase_r == PH_GAP_DASH) begin
            if (req.dot) pend_mid = PEND_DOT;
            else if (pend_r == PEND_NONE && req.dash) pend_mid = PEND_DASH;
          end else begin
            if (req.dash) pend_mid = PEND_DASH;
            else if (pend_r == PEND_NONE && req.dot) pend_mid = PEND_DOT;
          end
          pend_nxt = pend_mid;
          if (dot_end) begin
            tick_nxt = '0;
            pend_nxt = PEND_NONE;
            if (pend_mid == PEND_DASH)     phase_nxt = PH_DASH;
            else if (pend_mid == PEND_DOT) phase_nxt = PH_DOT;
            else                           phase_nxt = PH_IDLE;
          end
        end
        default: begin
          // idle; dash wins when both paddles are down
          if (req.dash) begin
            phase_nxt = PH_DASH;
            tick_nxt  = '0;
          end else if (req.dot) begin
            phase_nxt = PH_DOT;
            tick_nxt  = '0;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    unique case (phase_r)
      PH_DASH, PH_DOT: key = 1'b1;
      default:         key = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= PEND_NONE;
      tick_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/iambic_morse_keyer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Iambic paddle keyer with dot/dash memory. Each input word is one 1 ms
// tick carrying both paddle switches and a 10-bit speed sample; each tick
// returns exactly one output word with the key state after that tick. A
// tick goes through these steps after the accepting edge: scale the
// sample (sample/7 + 50, done as a reciprocal multiply), load the
// divider, run the bit-serial divide 6000/(sample/7 + 50) that yields
// the dot length, advance the keyer state in the cycle in which the
// divider reports done, and load the output. in_ready is low from the
// accepting edge until the sequencer is back in idle, so a new tick is
// not accepted before the last one has been pushed to the output
// register; a consumer stall holds that push while the output register
// is occupied. A finished word waiting in the output register does not
// block the next tick from being accepted. cfg_wdata written with cfg_we
// swaps the paddles (1 makes switch one the dot paddle); write it only
// while the keyer is quiet.
module iambic_morse_keyer_core
  import imk_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_switch_one_pressed,
  input  wire logic                in_switch_two_pressed,
  input  wire logic [SAMPLE_W-1:0] in_speed_sample,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_key_out
);

  // configuration
  logic swap_r;

  // sequencer
  seq_t seq_r, seq_nxt;

  // latched tick word
  logic                 dash_r, dot_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [DIVISOR_W-1:0] divisor_r;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_key_r;

  logic                 in_fire;
  logic                 div_start;
  logic                 div_done;
  logic [DOT_W-1:0]     dot_len;
  logic                 key;
  logic                 push;
  logic                 out_free;
  logic [PROD_W-1:0]    prod;
  step_req_t            step_req;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // sample/7 by reciprocal: exact for all 10-bit samples
  assign prod = PROD_W'(sample_r) * PROD_W'(RECIP7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      swap_r <= cfg_wdata;
    end
  end

  // paddle roles resolved at accept time
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dash_r   <= swap_r ? in_switch_two_pressed : in_switch_one_pressed;
      dot_r    <= swap_r ? in_switch_one_pressed : in_switch_two_pressed;
      sample_r <= in_speed_sample;
    end
    if (seq_r == SQ_SCALE) begin
      divisor_r <= prod[RECIP_SH +: DIVISOR_W] + DIV_OFFSET;
    end
  end

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SQ_IDLE:  if (in_valid) seq_nxt = SQ_SCALE;
      SQ_SCALE: seq_nxt = SQ_START;
      SQ_START: seq_nxt = SQ_DIV;
      SQ_DIV:   if (div_done) seq_nxt = SQ_PUSH;
      SQ_PUSH:  if (out_free) seq_nxt = SQ_IDLE;
      default:  seq_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    push      = 1'b0;
    step_req  = '{upd: 1'b0, dash: dash_r, dot: dot_r, dot_len: dot_len};
    unique case (seq_r)
      SQ_IDLE:  in_ready     = 1'b1;
      SQ_START: div_start    = 1'b1;
      SQ_DIV:   step_req.upd = div_done;
      SQ_PUSH:  push         = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  imk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DOT_NUM),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (dot_len)
  );

  imk_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (step_req),
    .key   (key)
  );

  // output register; holds while the consumer stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push)                        out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_key_r <= key;
  end

  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;

endmodule

`default_nettype wire

@@ hdl/imk_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imk_chk
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_key_out
);

  // words accepted but not yet delivered
  logic [1:0] owed_r, owed_nxt;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    owed_nxt = owed_r;
    if (in_fire && !out_fire)      owed_nxt = owed_r + 1'b1;
    else if (!in_fire && out_fire) owed_nxt = owed_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_out))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while a tick is in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> owed_r != 2'd0)
    else $error("output word with no tick owed");

  a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r != 2'd3)
    else $error("more than two ticks outstanding");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r == 2'd2 |-> !in_ready)
    else $error("accepting with output and divider both occupied");

endmodule

bind iambic_morse_keyer_core imk_chk u_imk_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_key_out (out_key_out)
);

`default_nettype wire
